>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros : concurrent assertion helpers for the rasterizer core
// clocked on the rising edge, held off while reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define SLR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scaled line rasterizer assertion failed");

// same cycle implication
`define SLR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    `SLR_ASSERT(label, clk, rst_n, (ante) |-> (cons))

// next cycle implication
`define SLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `SLR_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

>>> rtl/core/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// shared widths, register codes, reset values and types of the rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

    localparam int unsigned REG_BITS       = 16;
    localparam int unsigned SIZE_BITS      = 7;
    localparam int unsigned CELL_BITS      = 6;
    localparam int unsigned COLOUR_BITS    = 4;
    localparam int unsigned CFG_IDX_BITS   = 3;
    localparam int unsigned NUM_PTS        = 4;

    localparam int unsigned DEF_SCREEN_MAX = 64;
    localparam int unsigned DEF_COORD_BITS = 16;
    localparam int unsigned DEF_NUM_W      = REG_BITS + CELL_BITS;

    localparam logic signed [REG_BITS-1:0] RST_X_LOW  = 16'sd0;
    localparam logic signed [REG_BITS-1:0] RST_X_HIGH = 16'sd25600;
    localparam logic signed [REG_BITS-1:0] RST_Y_LOW  = 16'sd0;
    localparam logic signed [REG_BITS-1:0] RST_Y_HIGH = 16'sd25600;
    localparam logic [SIZE_BITS-1:0]       RST_WIDTH  = 7'd64;
    localparam logic [SIZE_BITS-1:0]       RST_HEIGHT = 7'd64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WORLD_X_LOW   = 3'd0,
        CFG_WORLD_X_HIGH  = 3'd1,
        CFG_WORLD_Y_LOW   = 3'd2,
        CFG_WORLD_Y_HIGH  = 3'd3,
        CFG_SCREEN_WIDTH  = 3'd4,
        CFG_SCREEN_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [REG_BITS-1:0] x_lo;
        logic signed [REG_BITS-1:0] x_hi;
        logic signed [REG_BITS-1:0] y_lo;
        logic signed [REG_BITS-1:0] y_hi;
        logic [CELL_BITS-1:0]       last_w;
        logic [CELL_BITS-1:0]       last_h;
    } t_cfg;

    typedef struct packed {
        logic [CELL_BITS-1:0]   start_col;
        logic [CELL_BITS-1:0]   start_row;
        logic [CELL_BITS-1:0]   end_col;
        logic [CELL_BITS-1:0]   end_row;
        logic [COLOUR_BITS-1:0] colour;
    } t_seg;

endpackage

`default_nettype wire

>>> rtl/core/scaled_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// scaled_line_rasterizer_unit
// draws a world-space line segment as a run of screen cells
// ----------------------------------------------------------------------------
// input channel: start and end point (signed q8.8) plus colour, one segment
// per transfer on i_in_valid / o_in_stall
// output channel: one cell per transfer on o_out_valid / i_out_stall, the
// end cell flagged by o_last_cell; a segment gives max(|dx|,|dy|)+1 cells
// config port: i_cfg_wr_en writes i_cfg_data to register i_cfg_index; the user
// must write only while no segment is in flight, which the block does not enforce
// endpoint mapping does one multiply per coordinate, then a compare-subtract
// per quotient bit on the shared divider step unless the cell is settled early;
// the mapper holds the finished segment until the walker, once idle, takes it
// cells then leave at one per cycle while the receiver does not stall; the
// walker goes idle after the last cell of a segment, so o_out_valid drops
// between the cells of consecutive segments
// the input stalls until the walker has taken the mapped segment, longer while
// the walker still holds the previous one, so no new segment enters mid-mapping;
// a stalled receiver holds the current cell and the walk
// reset: config returns to its defaults, both stages go idle, no cell pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scaled_line_rasterizer_unit
    import slr_pkg::*;
#(
    parameter int unsigned SCREEN_MAX = DEF_SCREEN_MAX,
    parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [REG_BITS-1:0]          i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic [COLOUR_BITS-1:0]       i_colour,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [CELL_BITS-1:0]              o_cell_column,
    output logic [CELL_BITS-1:0]              o_cell_row,
    output logic [COLOUR_BITS-1:0]            o_cell_colour,
    output logic                              o_last_cell
);

    logic signed [REG_BITS-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic [SIZE_BITS-1:0]       r_width, r_height;

    t_cfg w_cfg;
    t_seg w_seg;
    logic w_seg_valid;
    logic w_seg_take;

    // last usable index, size clamped to 1 .. SCREEN_MAX
    function automatic logic [CELL_BITS-1:0] f_last(input logic [SIZE_BITS-1:0] v);
        if (v > SIZE_BITS'(SCREEN_MAX)) begin
            return CELL_BITS'(SCREEN_MAX - 1);
        end else if (v == '0) begin
            return '0;
        end else begin
            return CELL_BITS'(v - 1'b1);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= RST_X_LOW;
            r_x_high <= RST_X_HIGH;
            r_y_low  <= RST_Y_LOW;
            r_y_high <= RST_Y_HIGH;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WORLD_X_LOW:   r_x_low  <= $signed(i_cfg_data);
                CFG_WORLD_X_HIGH:  r_x_high <= $signed(i_cfg_data);
                CFG_WORLD_Y_LOW:   r_y_low  <= $signed(i_cfg_data);
                CFG_WORLD_Y_HIGH:  r_y_high <= $signed(i_cfg_data);
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data[SIZE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.x_lo   = r_x_low;
    assign w_cfg.x_hi   = r_x_high;
    assign w_cfg.y_lo   = r_y_low;
    assign w_cfg.y_hi   = r_y_high;
    assign w_cfg.last_w = f_last(r_width);
    assign w_cfg.last_h = f_last(r_height);

    slr_mapper #(
        .COORD_BITS (COORD_BITS)
    ) u_mapper (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_colour    (i_colour),
        .o_seg_valid (w_seg_valid),
        .i_seg_take  (w_seg_take),
        .o_seg       (w_seg)
    );

    slr_walker u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg_valid   (w_seg_valid),
        .o_seg_take    (w_seg_take),
        .i_seg         (w_seg),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_column (o_cell_column),
        .o_cell_row    (o_cell_row),
        .o_cell_colour (o_cell_colour),
        .o_last_cell   (o_last_cell)
    );

endmodule

`default_nettype wire

>>> rtl/core/slr_divstep.sv
// ----------------------------------------------------------------------------
// slr_divstep
// shared compare and subtract unit of the restoring divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_divstep
    import slr_pkg::*;
#(
    parameter int unsigned W = DEF_NUM_W
) (
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_dvs,
    output logic              o_ge,
    output logic [W-1:0]      o_diff
);

    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_rem} - {1'b0, i_dvs};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/slr_mapper.sv
// ----------------------------------------------------------------------------
// slr_mapper
// maps the four endpoint coordinates to screen cells, one after the other,
// with a multiply then a bit-per-cycle division by the world span
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_mapper
    import slr_pkg::*;
#(
    parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cfg                         i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic [COLOUR_BITS-1:0]       i_colour,
    output logic                              o_seg_valid,
    input  wire logic                         i_seg_take,
    output t_seg                              o_seg
);

    localparam int unsigned DW     = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 1;
    localparam int unsigned NW     = DW - 1 + CELL_BITS;
    localparam int unsigned DVS_W  = REG_BITS + CELL_BITS;
    localparam int unsigned SPAN_W = REG_BITS + 1;
    localparam int unsigned BIT_W  = $clog2(CELL_BITS + 1);
    localparam int unsigned PT_W   = $clog2(NUM_PTS);
    localparam logic [PT_W-1:0]  PT_LAST  = PT_W'(NUM_PTS - 1);
    localparam logic [BIT_W-1:0] BIT_OVFL = BIT_W'(CELL_BITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } t_map_state;

    t_map_state r_state, n_state;
    logic [PT_W-1:0]  r_pt, n_pt;

    logic signed [COORD_BITS-1:0] r_coord [NUM_PTS];
    logic signed [COORD_BITS-1:0] n_coord [NUM_PTS];
    logic [CELL_BITS-1:0]         r_res   [NUM_PTS];
    logic [CELL_BITS-1:0]         n_res   [NUM_PTS];
    logic [COLOUR_BITS-1:0]       r_colour, n_colour;
    logic [NW-1:0]                r_rem, n_rem;
    logic [DVS_W-1:0]             r_dvs, n_dvs;
    logic [BIT_W-1:0]             r_bit, n_bit;
    logic [CELL_BITS-1:0]         r_q, n_q;

    logic                    w_is_y;
    logic signed [SPAN_W-1:0] w_span;
    logic signed [DW-1:0]    w_op_a;
    logic signed [DW-1:0]    w_op_b;
    logic signed [DW-1:0]    w_diff;
    logic [CELL_BITS-1:0]    w_last;
    logic [NW-1:0]           w_prod;
    logic                    w_ge;
    logic [NW-1:0]           w_sub;
    logic [CELL_BITS-1:0]    w_q_bit;
    logic [CELL_BITS-1:0]    w_q_next;
    logic                    w_res_wr;
    logic [CELL_BITS-1:0]    w_res_val;

    // y rows use (hi - y) so the axis comes out flipped
    assign w_is_y = r_pt[0];
    assign w_span = w_is_y ? (SPAN_W'($signed(i_cfg.y_hi)) - SPAN_W'($signed(i_cfg.y_lo)))
                           : (SPAN_W'($signed(i_cfg.x_hi)) - SPAN_W'($signed(i_cfg.x_lo)));
    assign w_op_a = w_is_y ? DW'($signed(i_cfg.y_hi)) : DW'(r_coord[r_pt]);
    assign w_op_b = w_is_y ? DW'(r_coord[r_pt]) : DW'($signed(i_cfg.x_lo));
    assign w_diff = w_op_a - w_op_b;
    assign w_last = w_is_y ? i_cfg.last_h : i_cfg.last_w;
    assign w_prod = NW'(w_diff[DW-2:0]) * NW'(w_last);

    slr_divstep #(
        .W (NW)
    ) u_divstep (
        .i_rem  (r_rem),
        .i_dvs  (NW'(r_dvs)),
        .o_ge   (w_ge),
        .o_diff (w_sub)
    );

    assign w_q_bit  = CELL_BITS'(1) << r_bit;
    assign w_q_next = r_q | (w_ge ? w_q_bit : '0);

    always_comb begin
        n_state   = r_state;
        n_pt      = r_pt;
        n_coord   = r_coord;
        n_res     = r_res;
        n_colour  = r_colour;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_bit     = r_bit;
        n_q       = r_q;
        w_res_wr  = 1'b0;
        w_res_val = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_coord[0] = i_start_x;
                    n_coord[1] = i_start_y;
                    n_coord[2] = i_end_x;
                    n_coord[3] = i_end_y;
                    n_colour   = i_colour;
                    n_pt       = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                priority if (w_span <= 0) begin
                    w_res_wr  = 1'b1;
                    w_res_val = w_is_y ? w_last : '0;
                end else if (w_diff < 0) begin
                    w_res_wr  = 1'b1;
                    w_res_val = '0;
                end else begin
                    n_rem   = w_prod;
                    n_dvs   = {w_span[REG_BITS-1:0], {CELL_BITS{1'b0}}};
                    n_bit   = BIT_OVFL;
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == BIT_OVFL) begin
                    // quotient too big for a cell index
                    if (w_ge) begin
                        w_res_wr  = 1'b1;
                        w_res_val = w_last;
                    end else begin
                        n_bit = r_bit - 1'b1;
                        n_dvs = r_dvs >> 1;
                    end
                end else begin
                    if (w_ge) begin
                        n_rem = w_sub;
                    end
                    if (r_bit == '0) begin
                        w_res_wr  = 1'b1;
                        w_res_val = (w_q_next > w_last) ? w_last : w_q_next;
                    end else begin
                        n_q   = w_q_next;
                        n_bit = r_bit - 1'b1;
                        n_dvs = r_dvs >> 1;
                    end
                end
            end
            S_HOLD: begin
                if (i_seg_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_res_wr) begin
            n_res[r_pt] = w_res_val;
            if (r_pt == PT_LAST) begin
                n_state = S_HOLD;
            end else begin
                n_pt    = r_pt + 1'b1;
                n_state = S_MUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pt    <= '0;
        end else begin
            r_state <= n_state;
            r_pt    <= n_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coord  <= n_coord;
        r_res    <= n_res;
        r_colour <= n_colour;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_bit    <= n_bit;
        r_q      <= n_q;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_seg_valid       = (r_state == S_HOLD);
    assign o_seg.start_col   = r_res[0];
    assign o_seg.start_row   = r_res[1];
    assign o_seg.end_col     = r_res[2];
    assign o_seg.end_row     = r_res[3];
    assign o_seg.colour      = r_colour;

endmodule

`default_nettype wire

>>> rtl/core/slr_walker.sv
// ----------------------------------------------------------------------------
// slr_walker
// bresenham walk from start cell to end cell, one cell per output transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module slr_walker
    import slr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_seg_valid,
    output logic                        o_seg_take,
    input  wire t_seg                   i_seg,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [CELL_BITS-1:0]        o_cell_column,
    output logic [CELL_BITS-1:0]        o_cell_row,
    output logic [COLOUR_BITS-1:0]      o_cell_colour,
    output logic                        o_last_cell
);

    localparam int unsigned ERR_W = CELL_BITS + 2;
    localparam int unsigned E2_W  = ERR_W + 1;

    logic                        r_busy, n_busy;
    logic [CELL_BITS-1:0]        r_cur_col, n_cur_col;
    logic [CELL_BITS-1:0]        r_cur_row, n_cur_row;
    logic [CELL_BITS-1:0]        r_goal_col, n_goal_col;
    logic [CELL_BITS-1:0]        r_goal_row, n_goal_row;
    logic [CELL_BITS-1:0]        r_span_x, n_span_x;
    logic [CELL_BITS-1:0]        r_span_y, n_span_y;
    logic                        r_dir_x_neg, n_dir_x_neg;
    logic                        r_dir_y_neg, n_dir_y_neg;
    logic signed [ERR_W-1:0]     r_err, n_err;
    logic [COLOUR_BITS-1:0]      r_colour, n_colour;

    logic                        w_done;
    logic                        w_xfer;
    logic signed [E2_W-1:0]      w_e2;
    logic signed [E2_W-1:0]      w_dx;
    logic signed [E2_W-1:0]      w_dy;
    logic                        w_step_x;
    logic                        w_step_y;
    logic signed [E2_W-1:0]      w_err_next;
    logic                        w_ld_xneg;
    logic                        w_ld_yneg;
    logic [CELL_BITS-1:0]        w_ld_sx;
    logic [CELL_BITS-1:0]        w_ld_sy;

    assign w_done     = (r_cur_col == r_goal_col) && (r_cur_row == r_goal_row);
    assign w_xfer     = r_busy && !i_out_stall;
    assign o_seg_take = i_seg_valid && !r_busy;

    assign w_e2     = {r_err, 1'b0};
    assign w_dx     = $signed({{(E2_W-CELL_BITS){1'b0}}, r_span_x});
    assign w_dy     = $signed({{(E2_W-CELL_BITS){1'b0}}, r_span_y});
    assign w_step_x = (w_e2 > -w_dy);
    assign w_step_y = (w_e2 < w_dx);
    assign w_err_next = E2_W'(r_err) - (w_step_x ? w_dy : '0) + (w_step_y ? w_dx : '0);

    assign w_ld_xneg = !(i_seg.start_col < i_seg.end_col);
    assign w_ld_yneg = !(i_seg.start_row < i_seg.end_row);
    assign w_ld_sx   = w_ld_xneg ? (i_seg.start_col - i_seg.end_col)
                                 : (i_seg.end_col - i_seg.start_col);
    assign w_ld_sy   = w_ld_yneg ? (i_seg.start_row - i_seg.end_row)
                                 : (i_seg.end_row - i_seg.start_row);

    always_comb begin
        n_busy      = r_busy;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_goal_col  = r_goal_col;
        n_goal_row  = r_goal_row;
        n_span_x    = r_span_x;
        n_span_y    = r_span_y;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_err       = r_err;
        n_colour    = r_colour;

        priority if (o_seg_take) begin
            n_busy      = 1'b1;
            n_cur_col   = i_seg.start_col;
            n_cur_row   = i_seg.start_row;
            n_goal_col  = i_seg.end_col;
            n_goal_row  = i_seg.end_row;
            n_span_x    = w_ld_sx;
            n_span_y    = w_ld_sy;
            n_dir_x_neg = w_ld_xneg;
            n_dir_y_neg = w_ld_yneg;
            n_err       = ERR_W'($signed({2'b00, w_ld_sx})) - ERR_W'($signed({2'b00, w_ld_sy}));
            n_colour    = i_seg.colour;
        end else if (w_xfer) begin
            if (w_done) begin
                n_busy = 1'b0;
            end else begin
                n_err = ERR_W'(w_err_next);
                if (w_step_x) begin
                    n_cur_col = r_dir_x_neg ? (r_cur_col - 1'b1) : (r_cur_col + 1'b1);
                end
                if (w_step_y) begin
                    n_cur_row = r_dir_y_neg ? (r_cur_row - 1'b1) : (r_cur_row + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_goal_col  <= '0;
            r_goal_row  <= '0;
            r_span_x    <= '0;
            r_span_y    <= '0;
            r_dir_x_neg <= 1'b0;
            r_dir_y_neg <= 1'b0;
            r_err       <= '0;
            r_colour    <= '0;
        end else begin
            r_busy      <= n_busy;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_goal_col  <= n_goal_col;
            r_goal_row  <= n_goal_row;
            r_span_x    <= n_span_x;
            r_span_y    <= n_span_y;
            r_dir_x_neg <= n_dir_x_neg;
            r_dir_y_neg <= n_dir_y_neg;
            r_err       <= n_err;
            r_colour    <= n_colour;
        end
    end

    assign o_out_valid   = r_busy;
    assign o_cell_column = r_cur_col;
    assign o_cell_row    = r_cur_row;
    assign o_cell_colour = r_colour;
    assign o_last_cell   = w_done;

    `SLR_ASSERT_NEXT(a_last_ends_walk, i_clk, i_rst_n, w_xfer && w_done, !o_out_valid)
    `SLR_ASSERT_NEXT(a_walk_goes_on, i_clk, i_rst_n, w_xfer && !w_done, o_out_valid)
    `SLR_ASSERT_NEXT(a_cell_moves, i_clk, i_rst_n, w_xfer && !w_done, (r_cur_col != $past(r_cur_col)) || (r_cur_row != $past(r_cur_row)))

endmodule

`default_nettype wire

>>> dv/scaled_line_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_line_rasterizer_unit_tb
// segments go in on the valid/stall input channel and every emitted screen
// cell is checked, in order, against cells predicted from the window mapping
// and a Bresenham walk; a short directed table runs first, then random
// window settings, segments and stalls, with a long receiver hold-off and a
// drain pause
// ----------------------------------------------------------------------------

module scaled_line_rasterizer_unit_tb;
    import slr_pkg::*;

    localparam int SCREEN_CELLS   = DEF_SCREEN_MAX;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PCT       = 28;
    localparam int IDLE_SETTLE    = 40;
    localparam int END_SETTLE     = 100;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 60;
    localparam int PLAN_ROWS      = 26;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd6;

    localparam logic signed [15:0] C_MIN = 16'sh8000;
    localparam logic signed [15:0] C_MAX = 16'sh7FFF;

    // window choices per axis
    localparam int WIN_DEFAULT = 0;
    localparam int WIN_FULL    = 1;
    localparam int WIN_EMPTY   = 2;
    localparam int WIN_RANDOM  = 3;

    typedef struct packed {
        logic [CELL_BITS-1:0]   column;
        logic [CELL_BITS-1:0]   row;
        logic [COLOUR_BITS-1:0] colour;
        logic                   last;
    } cell_t;

    typedef enum logic [0:0] {ROW_SEGMENT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_BITS-1:0]    index;
        logic [REG_BITS-1:0]        data;
        logic signed [15:0]         sx;
        logic signed [15:0]         sy;
        logic signed [15:0]         ex;
        logic signed [15:0]         ey;
        logic [COLOUR_BITS-1:0]     colour;
        logic                       typed;
        logic [CELL_BITS-1:0]       tcol;
        logic [CELL_BITS-1:0]       trow;
    } plan_row_t;

    // directed stimulus, some single-cell rows carry their expected cell
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b1, 6'd0, 6'd63},
        '{ROW_SEGMENT, 3'd0, 16'h0, C_MAX, C_MAX, C_MAX, C_MAX, 4'hF, 1'b1, 6'd63, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, C_MIN, C_MIN, C_MIN, C_MIN, 4'h5, 1'b1, 6'd0, 6'd63},
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd25600, 16'sd25600, 16'sd25600, 16'sd25600,
          4'hA, 1'b1, 6'd63, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, C_MIN, C_MIN, C_MAX, C_MAX, 4'h3, 1'b0, 6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, C_MAX, C_MIN, C_MIN, C_MAX, 4'hC, 1'b0, 6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd0, 16'sd12800, 16'sd25600, 16'sd12800,
          4'h6, 1'b0, 6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd12800, 16'sd25600, 16'sd12800, 16'sd0,
          4'h9, 1'b0, 6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd1000, 16'sd2000, 16'sd20000, 16'sd5000,
          4'h7, 1'b0, 6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd20000, 16'sd3000, 16'sd4000, 16'sd24000,
          4'h8, 1'b0, 6'd0, 6'd0},
        // write to an index with no register behind it
        '{ROW_WRITE, CFG_UNUSED, 16'h0005, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd25600, 16'sd0, 16'sd0, 16'sd25600,
          4'h1, 1'b0, 6'd0, 6'd0},
        // reversed x span and empty y span
        '{ROW_WRITE, CFG_WORLD_X_HIGH, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_WRITE, CFG_WORLD_Y_HIGH, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, C_MIN, C_MAX, C_MAX, C_MIN, 4'hE, 1'b1, 6'd0, 6'd63},
        '{ROW_WRITE, CFG_WORLD_X_LOW, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_WRITE, CFG_WORLD_X_HIGH, 16'h7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_WRITE, CFG_WORLD_Y_LOW, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_WRITE, CFG_WORLD_Y_HIGH, 16'h7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        // sizes zero and one collapse the window to one cell
        '{ROW_WRITE, CFG_SCREEN_WIDTH, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_WRITE, CFG_SCREEN_HEIGHT, 16'hFF81, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, C_MAX, C_MAX, C_MIN, C_MIN, 4'h2, 1'b1, 6'd0, 6'd0},
        // oversize width acts as the full screen
        '{ROW_WRITE, CFG_SCREEN_WIDTH, 16'h007F, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_WRITE, CFG_SCREEN_HEIGHT, 16'h0002, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0, 1'b0,
          6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, C_MIN, C_MIN, C_MAX, C_MAX, 4'hB, 1'b0, 6'd0, 6'd0},
        '{ROW_SEGMENT, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'hD, 1'b0, 6'd0, 6'd0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index;
    logic [REG_BITS-1:0]           i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic signed [15:0]            i_start_x;
    logic signed [15:0]            i_start_y;
    logic signed [15:0]            i_end_x;
    logic signed [15:0]            i_end_y;
    logic [COLOUR_BITS-1:0]        i_colour;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [CELL_BITS-1:0]          o_cell_column;
    logic [CELL_BITS-1:0]          o_cell_row;
    logic [COLOUR_BITS-1:0]        o_cell_colour;
    logic                          o_last_cell;

    // window settings as the block should hold them
    logic signed [REG_BITS-1:0]    world_x_lo = RST_X_LOW;
    logic signed [REG_BITS-1:0]    world_x_hi = RST_X_HIGH;
    logic signed [REG_BITS-1:0]    world_y_lo = RST_Y_LOW;
    logic signed [REG_BITS-1:0]    world_y_hi = RST_Y_HIGH;
    logic [SIZE_BITS-1:0]          screen_w   = RST_WIDTH;
    logic [SIZE_BITS-1:0]          screen_h   = RST_HEIGHT;

    cell_t                         pending_cells [$];
    int                            segs_accepted = 0;
    int                            quiet_cycles  = 0;
    bit                            run_failed    = 1'b0;
    bit                            no_idle       = 1'b0;
    bit                            hold_request  = 1'b0;
    logic                          seg_typed;
    logic [CELL_BITS-1:0]          typed_column;
    logic [CELL_BITS-1:0]          typed_row;

    scaled_line_rasterizer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_colour      (i_colour),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_column (o_cell_column),
        .o_cell_row    (o_cell_row),
        .o_cell_colour (o_cell_colour),
        .o_last_cell   (o_last_cell)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint window_size(logic [SIZE_BITS-1:0] v);
        if (v > SCREEN_CELLS) return SCREEN_CELLS;
        if (v < 1) return 1;
        return v;
    endfunction

    function automatic logic [CELL_BITS-1:0] clamp_cell(longint q, longint last);
        if (q < 0) return '0;
        if (q > last) return last[CELL_BITS-1:0];
        return q[CELL_BITS-1:0];
    endfunction

    function automatic logic [CELL_BITS-1:0] column_of(logic signed [15:0] x);
        longint xv;
        longint lo;
        longint span;
        longint last;
        xv   = x;
        lo   = world_x_lo;
        span = longint'(world_x_hi) - lo;
        last = window_size(screen_w) - 1;
        if (span <= 0) return '0;
        return clamp_cell(((xv - lo) * last) / span, last);
    endfunction

    // row zero is the top, so the y axis is flipped
    function automatic logic [CELL_BITS-1:0] row_of(logic signed [15:0] y);
        longint yv;
        longint lo;
        longint span;
        longint last;
        yv   = y;
        lo   = world_y_lo;
        span = longint'(world_y_hi) - lo;
        last = window_size(screen_h) - 1;
        if (span <= 0) return last[CELL_BITS-1:0];
        return clamp_cell((last * (span - (yv - lo))) / span, last);
    endfunction

    // queue the cells of one segment in walk order
    function automatic void rasterize(logic signed [15:0] sx, logic signed [15:0] sy,
                                      logic signed [15:0] ex, logic signed [15:0] ey,
                                      logic [COLOUR_BITS-1:0] colour);
        int    cx;
        int    cy;
        int    gx;
        int    gy;
        int    dx;
        int    dy;
        int    err;
        int    e2;
        int    count;
        bit    x_neg;
        bit    y_neg;
        bit    stop;
        cell_t c;
        cx    = column_of(sx);
        cy    = row_of(sy);
        gx    = column_of(ex);
        gy    = row_of(ey);
        x_neg = !(cx < gx);
        y_neg = !(cy < gy);
        dx    = x_neg ? cx - gx : gx - cx;
        dy    = y_neg ? cy - gy : gy - cy;
        err   = dx - dy;
        count = 0;
        do begin
            c.column = cx[CELL_BITS-1:0];
            c.row    = cy[CELL_BITS-1:0];
            c.colour = colour;
            c.last   = (cx == gx) && (cy == gy);
            pending_cells.push_back(c);
            count++;
            stop = c.last || (count >= SCREEN_CELLS);
            if (!stop) begin
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    cx  += x_neg ? -1 : 1;
                end
                if (e2 < dx) begin
                    err += dx;
                    cy  += y_neg ? -1 : 1;
                end
            end
        end while (!stop);
    endfunction

    always @(posedge i_clk) begin : monitor_b
        cell_t want;
        bit    progress;
        if (i_rst_n) begin
            progress = i_cfg_wr_en;
            if (i_in_valid && !o_in_stall) begin
                progress = 1'b1;
                segs_accepted++;
                if (seg_typed) begin
                    want.column = typed_column;
                    want.row    = typed_row;
                    want.colour = i_colour;
                    want.last   = 1'b1;
                    pending_cells.push_back(want);
                end else begin
                    rasterize(i_start_x, i_start_y, i_end_x, i_end_y, i_colour);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                progress = 1'b1;
                if (pending_cells.size() == 0) begin
                    $error("unexpected cell: column %0d row %0d colour %0d last %0d",
                           o_cell_column, o_cell_row, o_cell_colour, o_last_cell);
                    run_failed = 1'b1;
                end else begin
                    want = pending_cells[0];
                    pending_cells.delete(0);
                    if (o_cell_column !== want.column) begin
                        $error("cell_column: expected %0d, got %0d", want.column, o_cell_column);
                        run_failed = 1'b1;
                    end
                    if (o_cell_row !== want.row) begin
                        $error("cell_row: expected %0d, got %0d", want.row, o_cell_row);
                        run_failed = 1'b1;
                    end
                    if (o_cell_colour !== want.colour) begin
                        $error("cell_colour: expected %0d, got %0d", want.colour, o_cell_colour);
                        run_failed = 1'b1;
                    end
                    if (o_last_cell !== want.last) begin
                        $error("last_cell: expected %0d, got %0d", want.last, o_last_cell);
                        run_failed = 1'b1;
                    end
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("scaled_line_rasterizer_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver side: random stalls, one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic drain_cells();
        i_in_valid = 1'b0;
        while (pending_cells.size() != 0) @(negedge i_clk);
    endtask

    task automatic wait_until_idle();
        drain_cells();
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] index, logic [REG_BITS-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        case (index)
            CFG_WORLD_X_LOW:   world_x_lo = data;
            CFG_WORLD_X_HIGH:  world_x_hi = data;
            CFG_WORLD_Y_LOW:   world_y_lo = data;
            CFG_WORLD_Y_HIGH:  world_y_hi = data;
            CFG_SCREEN_WIDTH:  screen_w   = data[SIZE_BITS-1:0];
            CFG_SCREEN_HEIGHT: screen_h   = data[SIZE_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_segment(logic signed [15:0] sx, logic signed [15:0] sy,
                                logic signed [15:0] ex, logic signed [15:0] ey,
                                logic [COLOUR_BITS-1:0] colour, logic typed,
                                logic [CELL_BITS-1:0] tcol, logic [CELL_BITS-1:0] trow);
        int seen;
        if (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_start_x    = sx;
        i_start_y    = sy;
        i_end_x      = ex;
        i_end_y      = ey;
        i_colour     = colour;
        seg_typed    = typed;
        typed_column = tcol;
        typed_row    = trow;
        i_in_valid   = 1'b1;
        seen         = segs_accepted;
        do @(negedge i_clk); while (segs_accepted == seen);
    endtask

    task automatic pick_span(int mode, output int lo, output int hi);
        case (mode)
            WIN_DEFAULT: begin
                lo = RST_X_LOW;
                hi = RST_X_HIGH;
            end
            WIN_FULL: begin
                lo = C_MIN;
                hi = C_MAX;
            end
            WIN_EMPTY: begin
                hi = int'($urandom_range(0, 65535)) - 32768;
                lo = hi + int'($urandom_range(0, 32767 - hi));
            end
            default: begin
                lo = int'($urandom_range(0, 64767)) - 32768;
                hi = lo + int'($urandom_range(1, 32767 - lo));
            end
        endcase
    endtask

    function automatic int random_mode();
        int r;
        r = $urandom_range(0, 9);
        return (r <= WIN_EMPTY) ? r : WIN_RANDOM;
    endfunction

    function automatic logic [REG_BITS-1:0] random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return REG_BITS'({$urandom_range(0, 511), 7'd0} | $urandom_range(2, 64));
        if (r < 80) return 16'd2;
        if (r < 90) return 16'd64;
        return REG_BITS'({$urandom_range(0, 511), 7'd0} | $urandom_range(0, 127));
    endfunction

    task automatic set_window(int x_mode, int y_mode, logic [REG_BITS-1:0] w_data,
                              logic [REG_BITS-1:0] h_data);
        int lo;
        int hi;
        pick_span(x_mode, lo, hi);
        write_register(CFG_WORLD_X_LOW, lo[REG_BITS-1:0]);
        write_register(CFG_WORLD_X_HIGH, hi[REG_BITS-1:0]);
        pick_span(y_mode, lo, hi);
        write_register(CFG_WORLD_Y_LOW, lo[REG_BITS-1:0]);
        write_register(CFG_WORLD_Y_HIGH, hi[REG_BITS-1:0]);
        write_register(CFG_SCREEN_WIDTH, w_data);
        write_register(CFG_SCREEN_HEIGHT, h_data);
    endtask

    // mostly inside the window, some anywhere, some at the extremes
    function automatic logic signed [15:0] pick_coord(int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 16'($urandom_range(0, 65535));
        if (r < 18) return r[0] ? C_MAX : C_MIN;
        if (hi > lo) return 16'(lo + int'($urandom_range(0, hi - lo)));
        return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = CFG_WORLD_X_LOW;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_start_x    = '0;
        i_start_y    = '0;
        i_end_x      = '0;
        i_end_y      = '0;
        i_colour     = '0;
        seg_typed    = 1'b0;
        typed_column = '0;
        typed_row    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_until_idle();
                write_register(plan[i].index, plan[i].data);
            end else begin
                send_segment(plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey,
                             plan[i].colour, plan[i].typed, plan[i].tcol, plan[i].trow);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_until_idle();
            case (phase)
                2:       set_window(WIN_FULL, WIN_FULL, 16'd64, 16'd64);
                4:       set_window(random_mode(), random_mode(), 16'd2, 16'd2);
                default: set_window(random_mode(), random_mode(), random_size(), random_size());
            endcase
            no_idle = (phase == 3);
            if (phase == 1) hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 5 && k == PHASE_ITEMS / 2) drain_cells();
                send_segment(pick_coord(world_x_lo, world_x_hi),
                             pick_coord(world_y_lo, world_y_hi),
                             pick_coord(world_x_lo, world_x_hi),
                             pick_coord(world_y_lo, world_y_hi),
                             COLOUR_BITS'($urandom_range(0, 15)), 1'b0, '0, '0);
            end
        end
        no_idle = 1'b0;

        drain_cells();
        repeat (END_SETTLE) @(negedge i_clk);
        if (!run_failed) begin
            $display("scaled_line_rasterizer_unit_tb: PASS");
        end else begin
            $display("scaled_line_rasterizer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/slr_pkg.sv
rtl/core/slr_divstep.sv
rtl/core/slr_mapper.sv
rtl/core/slr_walker.sv
rtl/core/scaled_line_rasterizer_unit.sv
dv/scaled_line_rasterizer_unit_tb.sv
